// File: src/tcf_pkg.sv
package tcf_pkg;

	localparam logic [7:0] BYTE_IAC  = 8'd255;
	localparam logic [7:0] BYTE_SB   = 8'd250;
	localparam logic [7:0] BYTE_SE   = 8'd240;
	localparam logic [7:0] BYTE_WILL = 8'd251;
	localparam logic [7:0] BYTE_WONT = 8'd252;
	localparam logic [7:0] BYTE_DO   = 8'd253;
	localparam logic [7:0] BYTE_DONT = 8'd254;

	localparam logic [8:0] PLAIN_LIMIT = 9'd3;

	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_OPT_FIRST  = 2'd0;
	localparam logic [1:0] REG_OPT_SECOND = 2'd1;
	localparam logic [1:0] REG_SUBNEG_LIM = 2'd2;

	localparam logic [7:0] OPT_FIRST_RST  = 8'd34;
	localparam logic [7:0] OPT_SECOND_RST = 8'd1;
	localparam logic [7:0] SUBNEG_LIM_RST = 8'd128;

	localparam int QUEUE_DEPTH_DEF = 4;

	typedef struct packed {
		logic [7:0] opt_first;
		logic [7:0] opt_second;
		logic [7:0] subneg_limit;
	} cfg_t;

	typedef struct packed {
		logic       is_reply;
		logic [7:0] cmd;
		logic [7:0] payload;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	function automatic logic [7:0] negate_cmd(input logic [7:0] c);
		logic [7:0] r;
		unique case (c)
			BYTE_WILL: r = BYTE_DONT;
			BYTE_DO:   r = BYTE_WONT;
			BYTE_WONT: r = BYTE_DO;
			BYTE_DONT: r = BYTE_WILL;
			default:   r = c;
		endcase
		return r;
	endfunction

endpackage

// File: src/tcf_ifs.sv
interface tcf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface tcf_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       out_kind;
	logic       last_of_run;

	modport source (output valid, output out_byte, output out_kind, output last_of_run,
		input ready);
	modport sink (input valid, input out_byte, input out_kind, input last_of_run,
		output ready);
endinterface

// File: src/telnet_command_filter.sv
// Telnet command filter: strips command sequences from a received byte stream and
// answers refused option requests. One byte is accepted per cycle while the record
// queue (QUEUE_DEPTH entries) has room; a data byte passes through the queue and the
// output register, a refused option produces a three-byte reply that the output
// register sends one byte at a time, and the queue absorbs bytes arriving meanwhile.
// Swallowed bytes produce nothing. The output side therefore sets the sustained rate:
// one result per cycle when not stalled. No clearing pass is needed after reset.
module telnet_command_filter import tcf_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tcf_byte_if.sink          items,
	tcf_result_if.source      results,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t    cfg;
	q_stat_t qst;
	logic    push;
	rec_t    push_rec;
	logic    pop;
	rec_t    head;

	tcf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.cfg    (cfg),
		.qst    (qst),
		.push   (push),
		.rec    (push_rec)
	);

	tcf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head     (head),
		.qst      (qst)
	);

	tcf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.qst     (qst),
		.pop     (pop),
		.results (results)
	);

endmodule

// File: src/tcf_regs.sv
module tcf_regs import tcf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.opt_first    <= OPT_FIRST_RST;
			cfg_q.opt_second   <= OPT_SECOND_RST;
			cfg_q.subneg_limit <= SUBNEG_LIM_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_OPT_FIRST:  cfg_q.opt_first    <= pwdata[7:0];
				REG_OPT_SECOND: cfg_q.opt_second   <= pwdata[7:0];
				REG_SUBNEG_LIM: cfg_q.subneg_limit <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_OPT_FIRST:  prdata = {24'd0, cfg_q.opt_first};
			REG_OPT_SECOND: prdata = {24'd0, cfg_q.opt_second};
			REG_SUBNEG_LIM: prdata = {24'd0, cfg_q.subneg_limit};
			default:        prdata = 32'd0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg    = cfg_q;

endmodule

// File: src/tcf_front.sv
module tcf_front import tcf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	tcf_byte_if.sink items,
	input  cfg_t   cfg,
	input  q_stat_t qst,
	output logic   push,
	output rec_t   rec
);

	logic [7:0] pos_q;
	logic       subneg_q;
	logic [7:0] cmd_q;

	logic [7:0] pos_d;
	logic       subneg_d;
	logic [7:0] cmd_d;
	logic [8:0] nxt;
	logic [8:0] lim;
	logic [7:0] reply;
	logic       push_c;
	logic       accept;
	logic [7:0] b;

	assign b      = items.in_byte;
	assign accept = items.valid && items.ready;

	always_comb begin
		nxt          = {1'b0, pos_q} + 9'd1;
		lim          = subneg_q ? {1'b0, cfg.subneg_limit} : PLAIN_LIMIT;
		reply        = negate_cmd(cmd_q);
		pos_d        = pos_q;
		subneg_d     = subneg_q;
		cmd_d        = cmd_q;
		push_c       = 1'b0;
		rec.is_reply = 1'b0;
		rec.cmd      = reply;
		rec.payload  = b;
		if (b == BYTE_IAC) begin
			pos_d    = 8'd1;
			subneg_d = 1'b0;
			cmd_d    = 8'd0;
		end else if (pos_q == 8'd0) begin
			push_c = 1'b1;
		end else if (nxt > lim) begin
			pos_d  = 8'd0;
			push_c = 1'b1;
		end else begin
			pos_d = nxt[7:0];
			if (nxt == 9'd2) begin
				cmd_d = b;
				if (b == BYTE_SB) begin
					subneg_d = 1'b1;
				end else if (b == BYTE_SE) begin
					pos_d    = 8'd0;
					subneg_d = 1'b0;
				end
			end else if (nxt == 9'd3) begin
				if (b != cfg.opt_first && b != cfg.opt_second && reply != 8'd0) begin
					push_c       = 1'b1;
					rec.is_reply = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= 8'd0;
			subneg_q <= 1'b0;
			cmd_q    <= 8'd0;
		end else if (accept) begin
			pos_q    <= pos_d;
			subneg_q <= subneg_d;
			cmd_q    <= cmd_d;
		end
	end

	assign items.ready = !qst.full;
	assign push        = accept && push_c;

endmodule

// File: src/tcf_queue.sv
module tcf_queue import tcf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rec_t    push_rec,
	input  logic    pop,
	output rec_t    head,
	output q_stat_t qst
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	rec_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign qst.full  = (count_q == CNT_W'(DEPTH));
	assign qst.empty = (count_q == '0);
	assign do_push   = push && !qst.full;
	assign do_pop    = pop && !qst.empty;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/tcf_back.sv
module tcf_back import tcf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rec_t    head,
	input  q_stat_t qst,
	output logic    pop,
	tcf_result_if.source results
);

	localparam logic [1:0] BEAT_IAC = 2'd0;
	localparam logic [1:0] BEAT_CMD = 2'd1;
	localparam logic [1:0] BEAT_OPT = 2'd2;

	logic [1:0] beat_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       out_kind_q;
	logic       out_last_q;

	logic       load;
	logic [7:0] byte_c;
	logic       last_c;
	logic [1:0] beat_d;

	assign load = !qst.empty && (!out_valid_q || results.ready);

	always_comb begin
		byte_c = head.payload;
		last_c = 1'b1;
		beat_d = BEAT_IAC;
		if (head.is_reply) begin
			unique case (beat_q)
				BEAT_IAC: begin
					byte_c = BYTE_IAC;
					last_c = 1'b0;
					beat_d = BEAT_CMD;
				end
				BEAT_CMD: begin
					byte_c = head.cmd;
					last_c = 1'b0;
					beat_d = BEAT_OPT;
				end
				BEAT_OPT: begin
					byte_c = head.payload;
					last_c = 1'b1;
					beat_d = BEAT_IAC;
				end
				default: begin
					byte_c = head.payload;
					last_c = 1'b1;
					beat_d = BEAT_IAC;
				end
			endcase
		end
	end

	assign pop = load && last_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q      <= BEAT_IAC;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				beat_q      <= beat_d;
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_c;
			out_kind_q <= head.is_reply;
			out_last_q <= last_c;
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_byte    = out_byte_q;
	assign results.out_kind    = out_kind_q;
	assign results.last_of_run = out_last_q;

endmodule

// File: src/tcf_checker.sv
module tcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [7:0] res_byte,
	input logic       res_kind,
	input logic       res_last
);

	logic res_take;

	assign res_take = res_valid && res_ready;

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_kind)
			&& $stable(res_last))
	else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_kind |-> res_last)
	else $error("data byte not marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		res_take && res_kind && !res_last |=> res_valid && res_kind)
	else $error("reply broken off");

	assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res_kind && !res_last) ##1 (res_take && res_kind && !res_last)
			|=> res_valid && res_kind && res_last)
	else $error("reply longer than three bytes");

endmodule

bind telnet_command_filter tcf_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (results.valid),
	.res_ready (results.ready),
	.res_byte  (results.out_byte),
	.res_kind  (results.out_kind),
	.res_last  (results.last_of_run)
);

// File: tb/sv/telnet_command_filter_tb.sv
`timescale 1ns / 100ps

module telnet_command_filter_tb;
	import tcf_pkg::*;

	localparam int IDLE_PCT = 35;
	localparam int DRAIN_CYCLES = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_BYTES = 34;
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(12);

	typedef struct packed {
		logic [7:0] value;
		logic       is_reply;
		logic       last;
	} out_rec_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	tcf_byte_if   rx_if ();
	tcf_result_if tx_if ();

	telnet_command_filter DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (rx_if),
		.results (tx_if),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	cfg_t       filter_cfg;
	logic [7:0] seq_pos;
	logic       in_subneg;
	logic [7:0] held_cmd;
	out_rec_t   pending_out[$];

	int error_count;
	int bytes_sent;
	int results_seen;
	int replies_seen;
	int stall_cycles;
	bit rx_steady;
	bit tx_steady;

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic [ADDR_W-1:0] reg_addr(input logic [1:0] idx);
		return ADDR_W'({idx, 2'b00});
	endfunction

	function automatic logic [7:0] refusal_of(input logic [7:0] c);
		case (c)
			BYTE_WILL: return BYTE_DONT;
			BYTE_DO:   return BYTE_WONT;
			BYTE_WONT: return BYTE_DO;
			BYTE_DONT: return BYTE_WILL;
			default:   return c;
		endcase
	endfunction

	function automatic void push_out(input logic [7:0] v, input logic r, input logic l);
		out_rec_t rec;
		rec.value = v;
		rec.is_reply = r;
		rec.last = l;
		pending_out.push_back(rec);
	endfunction

	function automatic void filter_byte(input logic [7:0] b);
		logic [8:0] nxt;
		logic [8:0] lim;
		logic [7:0] reply;
		if (b == BYTE_IAC) begin
			seq_pos = 8'd1;
			in_subneg = 1'b0;
			held_cmd = 8'd0;
			return;
		end
		if (seq_pos == 8'd0) begin
			push_out(b, 1'b0, 1'b1);
			return;
		end
		nxt = 9'(seq_pos) + 9'd1;
		lim = in_subneg ? 9'(filter_cfg.subneg_limit) : PLAIN_LIMIT;
		if (nxt > lim) begin
			seq_pos = 8'd0;
			push_out(b, 1'b0, 1'b1);
			return;
		end
		seq_pos = nxt[7:0];
		if (nxt == 9'd2) begin
			held_cmd = b;
			if (b == BYTE_SB) begin
				in_subneg = 1'b1;
			end else if (b == BYTE_SE) begin
				seq_pos = 8'd0;
				in_subneg = 1'b0;
			end
			return;
		end
		if (nxt != 9'd3)
			return;
		if (b == filter_cfg.opt_first || b == filter_cfg.opt_second)
			return;
		reply = refusal_of(held_cmd);
		if (reply == 8'd0)
			return;
		push_out(BYTE_IAC, 1'b1, 1'b0);
		push_out(reply, 1'b1, 1'b0);
		push_out(b, 1'b1, 1'b1);
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] MISMATCH %s: got %0d, want %0d (output byte %0d)",
			$realtime, what, got, want, results_seen);
		error_count++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		while (!rx_steady && gap < 8 && $urandom_range(99) < IDLE_PCT)
			gap++;
		repeat (gap) begin
			@(negedge clk);
			rx_if.valid <= 1'b0;
			rx_if.in_byte <= 8'($urandom);
		end
		@(negedge clk);
		rx_if.valid <= 1'b1;
		rx_if.in_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		filter_byte(b);
		bytes_sent++;
	endtask

	task automatic wait_quiet();
		@(negedge clk);
		rx_if.valid <= 1'b0;
		while (pending_out.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [7:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == reg_addr(REG_OPT_FIRST))
			filter_cfg.opt_first = value;
		else if (addr == reg_addr(REG_OPT_SECOND))
			filter_cfg.opt_second = value;
		else if (addr == reg_addr(REG_SUBNEG_LIM))
			filter_cfg.subneg_limit = value;
	endtask

	task automatic reg_check(input logic [1:0] idx, input logic [7:0] want);
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= reg_addr(idx);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got != 32'(want))
			report_mismatch($sformatf("register %0d read-back", idx), int'(got), int'(want));
	endtask

	task automatic check_all_regs();
		reg_check(REG_OPT_FIRST, filter_cfg.opt_first);
		reg_check(REG_OPT_SECOND, filter_cfg.opt_second);
		reg_check(REG_SUBNEG_LIM, filter_cfg.subneg_limit);
	endtask

	task automatic set_filter(input logic [7:0] opt_a, input logic [7:0] opt_b,
		input logic [7:0] lim);
		wait_quiet();
		reg_write(reg_addr(REG_OPT_FIRST), opt_a);
		reg_write(reg_addr(REG_OPT_SECOND), opt_b);
		reg_write(reg_addr(REG_SUBNEG_LIM), lim);
		check_all_regs();
	endtask

	function automatic logic [7:0] pick_command();
		case ($urandom_range(7))
			0: return BYTE_WILL;
			1: return BYTE_WONT;
			2: return BYTE_DO;
			3: return BYTE_DONT;
			4: return BYTE_SE;
			5: return 8'd0;
			default: return 8'($urandom_range(254));
		endcase
	endfunction

	function automatic logic [7:0] pick_option();
		case ($urandom_range(3))
			0: return filter_cfg.opt_first;
			1: return filter_cfg.opt_second;
			default: return 8'($urandom_range(254));
		endcase
	endfunction

	task automatic rand_traffic(input int n);
		logic [7:0] seq[$];
		int target;
		int pick;
		int len_max;
		target = bytes_sent + n;
		while (bytes_sent < target) begin
			seq.delete();
			pick = $urandom_range(99);
			if (pick < 50) begin
				seq.push_back(BYTE_IAC);
				seq.push_back(pick_command());
				seq.push_back(pick_option());
				if ($urandom_range(3) == 0)
					seq.push_back(8'($urandom_range(254)));
			end else if (pick < 72) begin
				seq.push_back(BYTE_IAC);
				seq.push_back(BYTE_SB);
				seq.push_back(pick_option());
				len_max = (filter_cfg.subneg_limit <= 8) ? int'(filter_cfg.subneg_limit) + 2 : 6;
				repeat ($urandom_range(len_max))
					seq.push_back(8'($urandom_range(254)));
				if ($urandom_range(1)) begin
					seq.push_back(BYTE_IAC);
					seq.push_back(BYTE_SE);
				end
			end else if (pick < 88) begin
				seq.push_back(8'($urandom_range(254)));
			end else begin
				seq.push_back(8'($urandom));
			end
			foreach (seq[i])
				send_byte(seq[i]);
		end
	endtask

	task automatic test_register_defaults();
		check_all_regs();
	endtask

	task automatic test_option_negotiation();
		logic [7:0] stream[$] = '{
			8'h00, 8'hFE, 8'h80,
			BYTE_IAC, BYTE_WILL, 8'd34,
			BYTE_IAC, BYTE_DO, 8'd1,
			BYTE_IAC, BYTE_WILL, 8'd0,
			BYTE_IAC, BYTE_WONT, 8'd128,
			BYTE_IAC, BYTE_DONT, 8'd254,
			BYTE_IAC, 8'd0, 8'd5,
			BYTE_IAC, BYTE_IAC, 8'd17, 8'd6, 8'd99,
			BYTE_IAC, BYTE_SE
		};
		foreach (stream[i])
			send_byte(stream[i]);
	endtask

	task automatic test_subnegotiation();
		logic [7:0] stream[$] = '{
			BYTE_IAC, BYTE_SB, 8'd9, 8'd1, 8'd2, 8'd3, BYTE_IAC, BYTE_SE
		};
		foreach (stream[i])
			send_byte(stream[i]);
	endtask

	task automatic test_unused_register();
		wait_quiet();
		reg_write(ADDR_UNUSED, 8'hA5);
		check_all_regs();
		rand_traffic(4);
	endtask

	task automatic test_config_sweep();
		logic [7:0] opt_a_set[5] = '{8'd0, 8'd255, 8'd34, 8'd200, 8'd128};
		logic [7:0] opt_b_set[5] = '{8'd255, 8'd0, 8'd1, 8'd200, 8'd7};
		logic [7:0] lim_set[5] = '{8'd3, 8'd255, 8'd2, 8'd6, 8'd1};
		for (int p = 0; p < 5; p++) begin
			set_filter(opt_a_set[p], opt_b_set[p], lim_set[p]);
			rx_steady = (p == 1);
			tx_steady = (p == 1);
			rand_traffic(PHASE_BYTES);
		end
		rx_steady = 1'b0;
		tx_steady = 1'b0;
	endtask

	always @(negedge clk)
		tx_if.ready <= tx_steady || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin : result_check
		out_rec_t want;
		if (arst_n && tx_if.valid && tx_if.ready) begin
			results_seen++;
			if (tx_if.out_kind)
				replies_seen++;
			if (pending_out.size() == 0) begin
				report_mismatch("output byte with nothing pending", int'(tx_if.out_byte), -1);
			end else begin
				want = pending_out.pop_front();
				if (tx_if.out_byte !== want.value)
					report_mismatch("out_byte", int'(tx_if.out_byte), int'(want.value));
				if (tx_if.out_kind !== want.is_reply)
					report_mismatch("out_kind", int'(tx_if.out_kind), int'(want.is_reply));
				if (tx_if.last_of_run !== want.last)
					report_mismatch("last_of_run", int'(tx_if.last_of_run), int'(want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready) || psel)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = 8'd0;
		tx_if.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = 32'd0;
		error_count = 0;
		bytes_sent = 0;
		results_seen = 0;
		replies_seen = 0;
		stall_cycles = 0;
		rx_steady = 1'b0;
		tx_steady = 1'b0;
		filter_cfg.opt_first = OPT_FIRST_RST;
		filter_cfg.opt_second = OPT_SECOND_RST;
		filter_cfg.subneg_limit = SUBNEG_LIM_RST;
		seq_pos = 8'd0;
		in_subneg = 1'b0;
		held_cmd = 8'd0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_option_negotiation();
		test_subnegotiation();
		test_unused_register();
		test_config_sweep();
		wait_quiet();

		$display("Sent %0d input bytes, checked %0d output bytes (%0d reply bytes).",
			bytes_sent, results_seen, replies_seen);
		$display("Covered refusals, accepted options, sub-negotiation limits 1 to 255, read-back.");
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
